// File: rtl/feedback_frame_receiver_macros.svh
// Assertion macros shared by the feedback frame receiver RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef FEEDBACK_FRAME_RECEIVER_MACROS_SVH
`define FEEDBACK_FRAME_RECEIVER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define FFR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the trigger holds, the consequence holds in the same cycle.
`define FFR_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define FFR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ffr_pkg.sv
// Types and constants of the feedback frame receiver.
// Used by every module in the rtl folder; depends on nothing.
`default_nettype none

package ffr_pkg;

    localparam int TICK_COUNTER_BITS_DEFAULT = 32;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_WORD    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    localparam logic [15:0] START_WORD_RESET    = 16'hABCD;
    localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd160;

    // Frame layout: 18 bytes, nine little-endian words, word 8 is the checksum.
    localparam int IDX_BITS      = 5;
    localparam logic [IDX_BITS-1:0] IDX_IDLE      = 5'd0;
    localparam logic [IDX_BITS-1:0] IDX_FIRST     = 5'd2;
    localparam logic [IDX_BITS-1:0] IDX_LAST_XOR  = 5'd15;
    localparam logic [IDX_BITS-1:0] IDX_LAST_MID  = 5'd16;
    localparam logic [IDX_BITS-1:0] IDX_LAST      = 5'd17;
    localparam int SHIFT_LEN     = 15;
    localparam int PAYLOAD_WORDS = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic               new_frame;
        logic               bad_checksum;
        logic               timed_out;
        logic signed [15:0] command_one;
        logic signed [15:0] command_two;
        logic signed [15:0] speed_right;
        logic signed [15:0] speed_left;
        logic signed [15:0] battery_voltage;
        logic signed [15:0] board_temperature;
        logic [15:0]        led_word;
    } out_t;

    // One classified item handed from the front end to the back end.
    typedef struct packed {
        logic                               is_tick;
        logic                               good;
        logic                               bad;
        logic [PAYLOAD_WORDS-1:0][15:0]     words;
    } ev_t;

endpackage

`default_nettype wire

// File: rtl/ffr_front.sv
// Front end: takes bytes and ticks, tracks the frame and classifies each item.
// Depends on ffr_pkg and feedback_frame_receiver_macros.svh.
`default_nettype none
`include "feedback_frame_receiver_macros.svh"

module ffr_front
    import ffr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    input  wire logic [15:0] start_word,
    input  wire logic        q_full,
    output logic             q_push,
    output ev_t              q_ev
);

    logic [7:0]          prev_reg, prev_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [15:0]         word0_reg, word0_next;
    logic [7:0]          xlo_reg, xlo_next;
    logic [7:0]          xhi_reg, xhi_next;
    logic [7:0]          sh_reg [SHIFT_LEN];

    logic [7:0] b;
    logic       is_byte;
    logic       match;
    logic       complete;
    logic       frame_ok;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign b        = in_data.rx_byte;
    assign is_byte  = q_push && !in_data.cmd;
    assign match    = ({b, prev_reg} == start_word);
    assign complete = !match && (idx_reg == IDX_LAST);
    // Word 0 is checked against the marker as it stands now.
    assign frame_ok = (word0_reg == start_word) && (xlo_reg == sh_reg[SHIFT_LEN-1])
                      && (xhi_reg == b);

    always_comb
    begin
        prev_next  = prev_reg;
        idx_next   = idx_reg;
        word0_next = word0_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        if (is_byte)
        begin
            prev_next = b;
            if (match)
            begin
                idx_next   = IDX_FIRST;
                word0_next = {b, prev_reg};
                xlo_next   = prev_reg;
                xhi_next   = b;
            end
            else if (complete)
            begin
                idx_next = IDX_IDLE;
            end
            else if (idx_reg >= IDX_FIRST && idx_reg <= IDX_LAST_MID)
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg <= IDX_LAST_XOR)
                begin
                    if (idx_reg[0])
                        xhi_next = xhi_reg ^ b;
                    else
                        xlo_next = xlo_reg ^ b;
                end
            end
        end
    end

    always_comb
    begin
        q_ev.is_tick = in_data.cmd;
        q_ev.good    = !in_data.cmd && complete && frame_ok;
        q_ev.bad     = !in_data.cmd && complete && !frame_ok;
        // The shift line holds frame bytes 2 to 16 in order when byte 17 arrives.
        for (int k = 0; k < PAYLOAD_WORDS; k++)
        begin
            q_ev.words[k] = {sh_reg[2*k+1], sh_reg[2*k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            idx_reg   <= IDX_IDLE;
            word0_reg <= '0;
            xlo_reg   <= '0;
            xhi_reg   <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            idx_reg   <= idx_next;
            word0_reg <= word0_next;
            xlo_reg   <= xlo_next;
            xhi_reg   <= xhi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_byte)
        begin
            for (int i = 0; i < SHIFT_LEN - 1; i++)
            begin
                sh_reg[i] <= sh_reg[i+1];
            end
            sh_reg[SHIFT_LEN-1] <= b;
        end
    end

    `FFR_ASSERT_ALWAYS(a_idx_legal, (idx_reg == IDX_IDLE) || (idx_reg >= IDX_FIRST && idx_reg <= IDX_LAST), "frame index out of range")
    `FFR_ASSERT_SAME(a_complete_at_end, q_push && (q_ev.good || q_ev.bad), idx_reg == IDX_LAST, "frame completed early")
    `FFR_ASSERT_NEXT(a_complete_idles, q_push && (q_ev.good || q_ev.bad), idx_reg == IDX_IDLE, "index not cleared after frame")

endmodule

`default_nettype wire

// File: rtl/ffr_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on ffr_pkg.
`default_nettype none

module ffr_queue
    import ffr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire ev_t  push_ev,
    output logic      full,
    output logic      q_valid,
    input  wire logic pop,
    output ev_t       q_ev
);

    ev_t                  ent_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_ev    = ent_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= push_ev;
    end

endmodule

`default_nettype wire

// File: rtl/ffr_back.sv
// Back end: link timeout counter, latched frame words and the output register.
// Depends on ffr_pkg and feedback_frame_receiver_macros.svh.
`default_nettype none
`include "feedback_frame_receiver_macros.svh"

module ffr_back
    import ffr_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] timeout_ticks,
    input  wire logic        q_valid,
    input  wire ev_t         q_ev,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data
);

    // After reset the link counts as timed out and all payload words are zero.
    localparam out_t OUT_RESET = {2'b00, 1'b1, {PAYLOAD_WORDS{16'h0000}}};

    logic [TICK_COUNTER_BITS-1:0] cnt_reg, cnt_next, cnt_inc;
    out_t                         out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         over;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cnt_inc = (q_ev.is_tick && !(&cnt_reg)) ? cnt_reg + 1'b1 : cnt_reg;
    assign over    = (33'(cnt_inc) > {1'b0, timeout_ticks});

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            out_valid_next        = 1'b1;
            cnt_next              = cnt_inc;
            out_next.new_frame    = q_ev.good;
            out_next.bad_checksum = q_ev.bad;
            out_next.timed_out    = out_reg.timed_out || over;
            // The output register doubles as the latched word store.
            if (q_ev.good)
            begin
                cnt_next                   = '0;
                out_next.timed_out         = 1'b0;
                out_next.command_one       = $signed(q_ev.words[0]);
                out_next.command_two       = $signed(q_ev.words[1]);
                out_next.speed_right       = $signed(q_ev.words[2]);
                out_next.speed_left        = $signed(q_ev.words[3]);
                out_next.battery_voltage   = $signed(q_ev.words[4]);
                out_next.board_temperature = $signed(q_ev.words[5]);
                out_next.led_word          = q_ev.words[6];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg               <= '0;
            out_valid_reg         <= 1'b0;
            out_reg               <= OUT_RESET;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    `FFR_ASSERT_NEXT(a_good_clears, pop && q_ev.good, out_valid_reg && !out_reg.timed_out && cnt_reg == '0, "valid frame did not clear timeout")
    `FFR_ASSERT_NEXT(a_tick_no_frame, pop && q_ev.is_tick, !out_reg.new_frame && !out_reg.bad_checksum, "tick reported a frame")
    `FFR_ASSERT_ALWAYS(a_one_verdict, !(out_reg.new_frame && out_reg.bad_checksum), "frame both good and bad")

endmodule

`default_nettype wire

// File: rtl/feedback_frame_receiver.sv
// Top level of the feedback frame receiver: configuration registers and wiring
// of front end, queue and back end. Depends on ffr_pkg and the ffr_* modules.
//
// Usage: in_data carries one item per request, either a received UART byte
// (cmd 0) or one timer tick (cmd 1). Every item yields exactly one result on
// out_data: the good/bad frame verdict for a byte that ends a frame, the link
// timeout flag, and the payload words of the last frame accepted as good.
// Both channels are valid/ready. An item accepted at an edge is classified
// and written into the queue at that edge; the back end moves it from the
// queue into the output register once that register is empty or its word is
// being taken. One item per cycle is sustained while out_ready stays high.
// A two-entry queue lets the front keep accepting while the output waits;
// when out_ready stays low the queue fills and in_ready drops once it holds
// two items. Reset restores the default start word and timeout, sets the
// timeout flag, clears the payload words and tick counter, and drops any frame
// in progress. Configuration writes on cfg_we take effect at once.
`default_nettype none

module feedback_frame_receiver
    import ffr_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire in_t                       in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output out_t                           out_data,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [15:0] start_word_reg;
    logic [31:0] timeout_reg;
    logic        q_full;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    ev_t         push_ev;
    ev_t         head_ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= START_WORD_RESET;
            timeout_reg    <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_WORD:    start_word_reg <= cfg_data[15:0];
                CFG_TIMEOUT_TICKS: timeout_reg    <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    ffr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .start_word (start_word_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ev       (push_ev)
    );

    ffr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_ev (push_ev),
        .full    (q_full),
        .q_valid (q_valid),
        .pop     (q_pop),
        .q_ev    (head_ev)
    );

    ffr_back #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .q_valid       (q_valid),
        .q_ev          (head_ev),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data)
    );

endmodule

`default_nettype wire

// File: verif/feedback_frame_receiver_tb.sv
// Self-checking testbench for the feedback frame receiver: valid/ready driver and monitor,
// a per-request predictor of frame hunting, checksum and link timeout, and a watchdog.
// Depends on ffr_pkg and the feedback_frame_receiver RTL.
module feedback_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffr_pkg::*;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam int FRAME_BYTES = 18;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL_AT = 250;
    localparam int LONG_STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Requests waiting to be offered and status words waiting to come out.
    in_t rx_stream[$];
    out_t predicted_status[$];

    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned frames_good = 0;
    int unsigned frames_rejected = 0;
    int unsigned timeouts_seen = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;
    int send_wait = 0;
    int ready_hold = 0;
    int long_stall_left = 0;
    bit sender_idles = 1'b0;
    bit receiver_idles = 1'b0;
    bit long_stall_done = 1'b0;
    out_t expected_status;

    // Predictor state and its copy of the configuration.
    logic [15:0] cur_start_word;
    logic [31:0] cur_timeout;
    logic [7:0] last_byte;
    int frame_pos;
    logic [7:0] frame_buf [FRAME_BYTES];
    logic [15:0] latched [PAYLOAD_WORDS];
    logic link_lost;
    logic [TICK_COUNTER_BITS_DEFAULT-1:0] tick_count;

    feedback_frame_receiver i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] buf_word(int k);
        return {frame_buf[2 * k + 1], frame_buf[2 * k]};
    endfunction

    function automatic out_t decode_item(in_t item);
        out_t r;
        logic [15:0] pair;
        logic [15:0] sum;
        logic good;
        logic bad;
        int k;
        good = 1'b0;
        bad = 1'b0;
        if (item.cmd == CMD_TICK && tick_count != '1)
            tick_count = tick_count + 1'b1;
        // The timeout test runs on every request, before any frame can clear the flag.
        if (!link_lost && tick_count > cur_timeout)
            link_lost = 1'b1;
        if (item.cmd == CMD_BYTE)
        begin
            pair = {item.rx_byte, last_byte};
            if (pair == cur_start_word)
            begin
                frame_buf[0] = last_byte;
                frame_buf[1] = item.rx_byte;
                frame_pos = 2;
            end
            else if (frame_pos >= 2 && frame_pos < FRAME_BYTES)
            begin
                frame_buf[frame_pos] = item.rx_byte;
                frame_pos++;
            end
            if (frame_pos == FRAME_BYTES)
            begin
                sum = '0;
                for (k = 0; k < 8; k++)
                    sum = sum ^ buf_word(k);
                if (buf_word(0) == cur_start_word && sum == buf_word(8))
                begin
                    for (k = 0; k < PAYLOAD_WORDS; k++)
                        latched[k] = buf_word(k + 1);
                    link_lost = 1'b0;
                    tick_count = '0;
                    good = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
                frame_pos = 0;
            end
            last_byte = item.rx_byte;
        end
        r.new_frame = good;
        r.bad_checksum = bad;
        r.timed_out = link_lost;
        r.command_one = latched[0];
        r.command_two = latched[1];
        r.speed_right = latched[2];
        r.speed_left = latched[3];
        r.battery_voltage = latched[4];
        r.board_temperature = latched[5];
        r.led_word = latched[6];
        return r;
    endfunction

    task automatic compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic compare_flag(string name, logic want_v, logic got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %b, got %b", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Driver: offers queued requests, with a drawn gap after each one while sender_idles is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_status.push_back(decode_item(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (rx_stream.size() > 0)
                begin
                    in_data <= rx_stream.pop_front();
                    in_valid <= 1'b1;
                    send_wait = sender_idles ? $urandom_range(0, 19) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off so the internal queue fills and the input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_stall_left = 0;
        else if (!long_stall_done && results_seen >= LONG_STALL_AT)
        begin
            long_stall_left = LONG_STALL_CYCLES;
            long_stall_done = 1'b1;
        end
        else if (long_stall_left > 0)
            long_stall_left--;
    end

    // Monitor: checks each status word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: nothing expected, got %p", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    expected_status = predicted_status.pop_front();
                    compare_flag("new_frame", expected_status.new_frame, out_data.new_frame);
                    compare_flag("bad_checksum", expected_status.bad_checksum,
                                 out_data.bad_checksum);
                    compare_flag("timed_out", expected_status.timed_out, out_data.timed_out);
                    compare_field("command_one", expected_status.command_one,
                                  out_data.command_one);
                    compare_field("command_two", expected_status.command_two,
                                  out_data.command_two);
                    compare_field("speed_right", expected_status.speed_right,
                                  out_data.speed_right);
                    compare_field("speed_left", expected_status.speed_left, out_data.speed_left);
                    compare_field("battery_voltage", expected_status.battery_voltage,
                                  out_data.battery_voltage);
                    compare_field("board_temperature", expected_status.board_temperature,
                                  out_data.board_temperature);
                    compare_field("led_word", expected_status.led_word, out_data.led_word);
                    frames_good += expected_status.new_frame;
                    frames_rejected += expected_status.bad_checksum;
                    timeouts_seen += expected_status.timed_out;
                end
                results_seen++;
                ready_hold = receiver_idles ? $urandom_range(0, 19) : 0;
            end
            if (ready_hold > 0)
            begin
                ready_hold--;
                out_ready <= 1'b0;
            end
            else if (long_stall_left > 0)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_seen, items_queued);
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b);
        in_t it;
        it.cmd = CMD_BYTE;
        it.rx_byte = b;
        rx_stream.push_back(it);
        items_queued++;
    endtask

    task automatic push_tick();
        in_t it;
        it.cmd = CMD_TICK;
        it.rx_byte = 8'($urandom_range(0, 255));
        rx_stream.push_back(it);
        items_queued++;
    endtask

    // Ticks may arrive between any two bytes of a frame.
    task automatic frame_byte(logic [7:0] b);
        push_byte(b);
        if ($urandom_range(0, 9) == 0)
            push_tick();
    endtask

    task automatic send_frame(logic [PAYLOAD_WORDS-1:0][15:0] p, bit corrupt);
        logic [15:0] sum;
        int k;
        int flip;
        sum = cur_start_word;
        frame_byte(cur_start_word[7:0]);
        frame_byte(cur_start_word[15:8]);
        for (k = 0; k < PAYLOAD_WORDS; k++)
        begin
            sum = sum ^ p[k];
            frame_byte(p[k][7:0]);
            frame_byte(p[k][15:8]);
        end
        flip = $urandom_range(0, 15);
        if (corrupt)
            sum[flip] = ~sum[flip];
        frame_byte(sum[7:0]);
        frame_byte(sum[15:8]);
    endtask

    function automatic logic [PAYLOAD_WORDS-1:0][15:0] random_payload();
        logic [PAYLOAD_WORDS-1:0][15:0] p;
        int k;
        for (k = 0; k < PAYLOAD_WORDS; k++)
            case ($urandom_range(0, 7))
                0: p[k] = 16'h0000;
                1: p[k] = 16'hFFFF;
                2: p[k] = 16'h8000;
                3: p[k] = 16'h7FFF;
                default: p[k] = 16'($urandom_range(0, 65535));
            endcase
        return p;
    endfunction

    // Mostly well-formed frames, plus corrupted and cut-off frames, line noise and ticks.
    task automatic random_traffic(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_queued + count;
        while (items_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame(random_payload(), 1'b0);
            else if (pick < 70)
                send_frame(random_payload(), 1'b1);
            else if (pick < 78)
            begin
                push_byte(cur_start_word[7:0]);
                push_byte(cur_start_word[15:8]);
                repeat ($urandom_range(0, 14))
                    push_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 40))
                    push_tick();
        end
        // Leave the link fresh with a few ticks counted, for the next timeout setting.
        send_frame(random_payload(), 1'b0);
        repeat ($urandom_range(4, 8))
            push_tick();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen != items_queued);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_WORD)
            cur_start_word = value[15:0];
        else
            cur_timeout = value;
    endtask

    task automatic apply_setting(logic [15:0] marker, logic [31:0] limit);
        logic [CFG_DATA_BITS-1:0] value;
        // Upper bits of the marker write are noise that the block must drop.
        value = $urandom;
        value[15:0] = marker;
        write_reg(CFG_START_WORD, value);
        write_reg(CFG_TIMEOUT_TICKS, limit);
        settings_used++;
    endtask

    initial
    begin
        logic [PAYLOAD_WORDS-1:0][15:0] edge_words;
        int phase;
        int k;
        cur_start_word = START_WORD_RESET;
        cur_timeout = TIMEOUT_TICKS_RESET;
        last_byte = '0;
        frame_pos = 0;
        for (k = 0; k < FRAME_BYTES; k++)
            frame_buf[k] = '0;
        for (k = 0; k < PAYLOAD_WORDS; k++)
            latched[k] = '0;
        link_lost = 1'b1;
        tick_count = '0;
        edge_words = {16'h5AA5, 16'hFFFE, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: a tick while timed out, a frame cut short by a new start word, a frame
        // rejected for its checksum, a good frame with extreme payload, a tick and an idle byte.
        push_tick();
        push_byte(8'hCD);
        push_byte(8'hAB);
        push_byte(8'h10);
        push_byte(8'h20);
        push_byte(8'h30);
        push_byte(8'h40);
        send_frame(edge_words, 1'b1);
        send_frame(edge_words, 1'b0);
        push_tick();
        push_byte(8'h00);
        // First half of a frame whose marker is changed before it ends.
        push_byte(8'hCD);
        push_byte(8'hAB);
        for (k = 1; k <= 3; k++)
        begin
            push_byte(8'(k));
            push_byte(8'(k));
        end
        wait_drained();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        apply_setting(16'h0000, 32'd0);
        // Checksum is right, but word 0 no longer equals the marker: rejected.
        for (k = 4; k <= 7; k++)
        begin
            push_byte(8'(k));
            push_byte(8'(k));
        end
        push_byte(8'hCD);
        push_byte(8'hAB);
        push_tick();
        random_traffic(80);

        for (phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            sender_idles = (phase % 4) != 3 && (phase % 4) != 2;
            receiver_idles = (phase % 4) != 3 && (phase % 4) != 1;
            case (phase)
                0: apply_setting(16'hFFFF, 32'hFFFF_FFFF);
                1: apply_setting(16'($urandom_range(0, 65535)), 32'd3);
                2: apply_setting(16'($urandom_range(0, 65535)), 32'd20);
                3: apply_setting(START_WORD_RESET, TIMEOUT_TICKS_RESET);
                4: apply_setting(16'($urandom_range(0, 65535)), $urandom_range(0, 40));
                default: apply_setting(16'($urandom_range(0, 65535)), 32'd1);
            endcase
            // A byte first, so a lowered limit is noticed on a byte request.
            push_byte(8'($urandom_range(0, 255)));
            if (phase == 3)
                repeat (170)
                    push_tick();
            random_traffic(80);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_status.size() != 0)
        begin
            $display("%0t: %0d status words expected, none received", $time,
                     predicted_status.size());
            mismatches++;
        end
        $display("Checked %0d status words under %0d register settings.", results_seen,
                 settings_used);
        $display("Frames accepted: %0d, rejected: %0d, words with link down: %0d.",
                 frames_good, frames_rejected, timeouts_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ffr_pkg.sv
rtl/ffr_front.sv
rtl/ffr_queue.sv
rtl/ffr_back.sv
rtl/feedback_frame_receiver.sv
verif/feedback_frame_receiver_tb.sv
